### hdl/spf_pkg.sv
// Shared types and constants of the sensor packet framer.
package spf_pkg;

	// Fixed header bytes and length adjustment
	localparam logic [7:0]  START_HI  = 8'hEF;
	localparam logic [7:0]  START_LO  = 8'h01;
	localparam logic [15:0] LEN_EXTRA = 16'd2;

	// Command queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Output byte positions within a framed packet
	typedef enum logic [11:0] {
		PH_SOF_HI  = 12'b0000_0000_0001,
		PH_SOF_LO  = 12'b0000_0000_0010,
		PH_ADDR3   = 12'b0000_0000_0100,
		PH_ADDR2   = 12'b0000_0000_1000,
		PH_ADDR1   = 12'b0000_0001_0000,
		PH_ADDR0   = 12'b0000_0010_0000,
		PH_ID      = 12'b0000_0100_0000,
		PH_LEN_HI  = 12'b0000_1000_0000,
		PH_LEN_LO  = 12'b0001_0000_0000,
		PH_DATA    = 12'b0010_0000_0000,
		PH_CSUM_HI = 12'b0100_0000_0000,
		PH_CSUM_LO = 12'b1000_0000_0000
	} phase_t;

	// One classified payload beat, handed from front to back
	typedef struct packed {
		logic        first;
		logic        last;
		logic [7:0]  data;
		logic [7:0]  id;
		logic [15:0] flen;
		logic [15:0] csum;
	} cmd_t;

endpackage

### hdl/spf_if.sv
// Handshake channel interfaces: payload input, framed output, config write.
interface spf_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [7:0]  packet_id;
	logic [15:0] payload_len;
	modport source (output valid, output data_byte, output packet_id, output payload_len,
		input ready);
	modport sink (input valid, input data_byte, input packet_id, input payload_len,
		output ready);
endinterface

interface spf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface spf_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] device_address;
	modport source (output valid, output device_address, input ready);
	modport sink (input valid, input device_address, output ready);
endinterface

### hdl/spf_front.sv
// Front end: accepts payload beats, tracks packet progress and checksum.
module spf_front (
	input  logic            clk,
	input  logic            arst_n,
	spf_in_if.sink          pkt_in,
	input  logic            full,
	output logic            push,
	output spf_pkg::cmd_t   push_cmd
);

	logic [15:0] bytes_left_q;
	logic [15:0] running_sum_q;
	logic        first;
	logic        accept;
	logic [15:0] flen;
	logic [15:0] base_sum;
	logic [15:0] new_sum;
	logic [15:0] remain;

	assign pkt_in.ready = !full;
	assign accept       = pkt_in.valid && pkt_in.ready;
	assign first        = (bytes_left_q == 16'd0);

	// Header length and checksum seed
	assign flen     = pkt_in.payload_len + spf_pkg::LEN_EXTRA;
	assign base_sum = first ? (16'(pkt_in.packet_id) + 16'(flen[15:8]) + 16'(flen[7:0]))
	                        : running_sum_q;
	assign new_sum  = base_sum + 16'(pkt_in.data_byte);
	assign remain   = first ? pkt_in.payload_len : bytes_left_q;

	// Zero length while idle is dropped
	assign push = accept && !(first && pkt_in.payload_len == 16'd0);

	always_comb begin
		push_cmd.first = first;
		push_cmd.last  = (remain == 16'd1);
		push_cmd.data  = pkt_in.data_byte;
		push_cmd.id    = pkt_in.packet_id;
		push_cmd.flen  = flen;
		push_cmd.csum  = new_sum;
	end

	// Packet progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= 16'd0;
			running_sum_q <= 16'd0;
		end else if (push) begin
			bytes_left_q  <= remain - 16'd1;
			running_sum_q <= (remain == 16'd1) ? 16'd0 : new_sum;
		end
	end

endmodule

### hdl/spf_queue.sv
// Short command queue between front and back.
module spf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  spf_pkg::cmd_t   push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output spf_pkg::cmd_t   head_cmd
);

	spf_pkg::cmd_t                 mem_q [spf_pkg::QDEPTH];
	logic [spf_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [spf_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [spf_pkg::QCNT_W-1:0]    count_q;

	assign full       = (count_q == spf_pkg::QCNT_W'(spf_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == spf_pkg::QPTR_W'(spf_pkg::QDEPTH - 1)) ? '0
				                                                                 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == spf_pkg::QPTR_W'(spf_pkg::QDEPTH - 1)) ? '0
				                                                                 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/spf_back.sv
// Back end: expands queued commands into header, payload and checksum bytes.
module spf_back (
	input  logic            clk,
	input  logic            arst_n,
	spf_cfg_if.sink         cfg,
	input  logic            head_valid,
	input  spf_pkg::cmd_t   head_cmd,
	output logic            pop,
	spf_out_if.source       frm_out
);

	logic [31:0]     addr_q;
	spf_pkg::phase_t phase_q;
	spf_pkg::phase_t eff;
	spf_pkg::phase_t phase_nxt;
	logic            done;
	logic            adv;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_end_q;
	logic [7:0]      next_byte;

	// Address register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 32'hFFFF_FFFF;
		end else if (cfg.valid) begin
			addr_q <= cfg.device_address;
		end
	end

	// A continuation beat skips the header
	assign eff  = (phase_q == spf_pkg::PH_SOF_HI && !head_cmd.first) ? spf_pkg::PH_DATA
	                                                                  : phase_q;
	assign done = (eff == spf_pkg::PH_DATA && !head_cmd.last) || eff == spf_pkg::PH_CSUM_LO;
	assign adv  = head_valid && (!out_valid_q || frm_out.ready);
	assign pop  = adv && done;

	// Byte select and following position
	always_comb begin
		case (eff)
			spf_pkg::PH_SOF_HI: begin
				next_byte = spf_pkg::START_HI;
				phase_nxt = spf_pkg::PH_SOF_LO;
			end
			spf_pkg::PH_SOF_LO: begin
				next_byte = spf_pkg::START_LO;
				phase_nxt = spf_pkg::PH_ADDR3;
			end
			spf_pkg::PH_ADDR3: begin
				next_byte = addr_q[31:24];
				phase_nxt = spf_pkg::PH_ADDR2;
			end
			spf_pkg::PH_ADDR2: begin
				next_byte = addr_q[23:16];
				phase_nxt = spf_pkg::PH_ADDR1;
			end
			spf_pkg::PH_ADDR1: begin
				next_byte = addr_q[15:8];
				phase_nxt = spf_pkg::PH_ADDR0;
			end
			spf_pkg::PH_ADDR0: begin
				next_byte = addr_q[7:0];
				phase_nxt = spf_pkg::PH_ID;
			end
			spf_pkg::PH_ID: begin
				next_byte = head_cmd.id;
				phase_nxt = spf_pkg::PH_LEN_HI;
			end
			spf_pkg::PH_LEN_HI: begin
				next_byte = head_cmd.flen[15:8];
				phase_nxt = spf_pkg::PH_LEN_LO;
			end
			spf_pkg::PH_LEN_LO: begin
				next_byte = head_cmd.flen[7:0];
				phase_nxt = spf_pkg::PH_DATA;
			end
			spf_pkg::PH_DATA: begin
				next_byte = head_cmd.data;
				phase_nxt = spf_pkg::PH_CSUM_HI;
			end
			spf_pkg::PH_CSUM_HI: begin
				next_byte = head_cmd.csum[15:8];
				phase_nxt = spf_pkg::PH_CSUM_LO;
			end
			spf_pkg::PH_CSUM_LO: begin
				next_byte = head_cmd.csum[7:0];
				phase_nxt = spf_pkg::PH_SOF_HI;
			end
			default: begin
				next_byte = 8'h00;
				phase_nxt = spf_pkg::PH_SOF_HI;
			end
		endcase
	end

	// Position within the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spf_pkg::PH_SOF_HI;
		end else if (adv) begin
			phase_q <= done ? spf_pkg::PH_SOF_HI : phase_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (frm_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= next_byte;
			out_end_q  <= (eff == spf_pkg::PH_CSUM_LO);
		end
	end

	assign frm_out.valid      = out_valid_q;
	assign frm_out.frame_byte = out_byte_q;
	assign frm_out.frame_end  = out_end_q;

	// Checks
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase not one-hot");
	a_mid_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != spf_pkg::PH_SOF_HI |-> head_valid)
		else $error("command left the queue before it was fully sent");
	a_sof_byte: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eff == spf_pkg::PH_SOF_HI |=> out_valid_q && out_byte_q == spf_pkg::START_HI)
		else $error("start code not sent at packet start");
	a_end_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eff == spf_pkg::PH_CSUM_LO |-> pop)
		else $error("checksum low byte did not retire its command");

endmodule

### hdl/sensor_packet_framer_sum16.sv
// Path: an accepted beat is held in the command queue, then in the output byte register.
// Throughput: one output byte per cycle while frm_out is ready; mid-packet payload beats go
//   at one per cycle; a packet's first beat gives 10 bytes, its last 2 more (12 for one byte).
// The output byte register sets the rate; a 4-entry command queue decouples input from output.
// Reset (arst_n low, asynchronous): idle, queue empty, device address FFFFFFFF.
module sensor_packet_framer_sum16 (
	input  logic      clk,
	input  logic      arst_n,
	spf_in_if.sink    pkt_in,
	spf_out_if.source frm_out,
	spf_cfg_if.sink   cfg
);

	logic          push;
	logic          full;
	logic          pop;
	logic          head_valid;
	spf_pkg::cmd_t push_cmd;
	spf_pkg::cmd_t head_cmd;

	// Classify incoming beats
	spf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_in   (pkt_in),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Command queue
	spf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Byte emitter
	spf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.frm_out    (frm_out)
	);

endmodule
